FILE: rtl/prrs_pkg.sv
package prrs_pkg;

    localparam int MAX_SLOTS   = 16;
    localparam int SLOT_W      = $clog2(MAX_SLOTS);
    localparam int LEN_W       = $clog2(MAX_SLOTS + 1);
    localparam int UPC_W       = 5;
    localparam int UCODE_DEPTH = 1 << UPC_W;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [UPC_W-1:0]  upc_t;

    // operation codes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_SET   = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;
    localparam logic [1:0] STAT_CUR  = 2'd3;

    // run states of a slot
    localparam logic [1:0] RS_RUNNING  = 2'd0;
    localparam logic [1:0] RS_SLEEPING = 2'd1;
    localparam logic [1:0] RS_STOPPING = 2'd2;

    typedef enum logic [3:0] {
        A_NOP,
        A_IDX_ZERO,
        A_NEXT,
        A_IDX_CUR1,
        A_IDX_SUB,
        A_ALLOC,
        A_FULL,
        A_BADT,
        A_CURERR,
        A_CLEAR_SLOT,
        A_CLEAR_IDX,
        A_TRIM,
        A_SETST,
        A_SWITCH,
        A_EMIT
    } act_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IDX_GE_LEN,
        C_IDX_LT_LEN,
        C_IDX_UNUSED,
        C_BAD_SLOT,
        C_BAD_SET,
        C_SLOT_CUR,
        C_LEN_FULL,
        C_TRIM_STOP,
        C_LEN_ZERO,
        C_IDX_CUR,
        C_RUNNING,
        C_NOT_STOPPING,
        C_CNT_ZERO
    } cond_t;

    typedef enum logic [1:0] {
        ADDR_IDX,
        ADDR_SLOT,
        ADDR_LAST
    } addr_sel_t;

    typedef struct packed {
        act_t      act;
        cond_t     cond;
        addr_sel_t addr;
        upc_t      target;
    } uword_t;

    typedef struct packed {
        act_t      act;
        addr_sel_t addr;
    } dp_ctrl_t;

    typedef struct packed {
        logic       idx_ge_len;
        logic       len_full;
        logic       len_zero;
        logic       slot_lt_len;
        logic       slot_is_cur;
        logic       idx_is_cur;
        logic       cnt_zero;
        logic       rd_used;
        logic [1:0] rd_state;
    } dp_flags_t;

    // program labels
    localparam upc_t UPC_ALLOC    = upc_t'(0);
    localparam upc_t UPC_A_SCAN   = upc_t'(1);
    localparam upc_t UPC_A_APPEND = upc_t'(4);
    localparam upc_t UPC_A_TAKE   = upc_t'(5);
    localparam upc_t UPC_A_FULL   = upc_t'(6);
    localparam upc_t UPC_FREE     = upc_t'(7);
    localparam upc_t UPC_F_TRIM   = upc_t'(10);
    localparam upc_t UPC_BAD      = upc_t'(12);
    localparam upc_t UPC_CUR      = upc_t'(13);
    localparam upc_t UPC_SET      = upc_t'(14);
    localparam upc_t UPC_TICK     = upc_t'(16);
    localparam upc_t UPC_T_MOD    = upc_t'(18);
    localparam upc_t UPC_T_TEST   = upc_t'(20);
    localparam upc_t UPC_T_TRIM   = upc_t'(25);
    localparam upc_t UPC_T_LENCHK = upc_t'(27);
    localparam upc_t UPC_T_NEXT   = upc_t'(28);
    localparam upc_t UPC_T_SWITCH = upc_t'(29);
    localparam upc_t UPC_EMIT     = upc_t'(30);
    localparam upc_t UPC_NONE     = upc_t'(0);

    // each word: action, jump condition, table read port address, jump target
    localparam uword_t UCODE [UCODE_DEPTH] = '{
        // allocate
        '{A_IDX_ZERO,   C_NEVER,        ADDR_IDX,  UPC_NONE},
        '{A_NOP,        C_IDX_GE_LEN,   ADDR_IDX,  UPC_A_APPEND},
        '{A_NOP,        C_IDX_UNUSED,   ADDR_IDX,  UPC_A_TAKE},
        '{A_NEXT,       C_ALWAYS,       ADDR_IDX,  UPC_A_SCAN},
        '{A_NOP,        C_LEN_FULL,     ADDR_IDX,  UPC_A_FULL},
        '{A_ALLOC,      C_ALWAYS,       ADDR_IDX,  UPC_EMIT},
        '{A_FULL,       C_ALWAYS,       ADDR_IDX,  UPC_EMIT},
        // free
        '{A_NOP,        C_BAD_SLOT,     ADDR_SLOT, UPC_BAD},
        '{A_NOP,        C_SLOT_CUR,     ADDR_SLOT, UPC_CUR},
        '{A_CLEAR_SLOT, C_NEVER,        ADDR_SLOT, UPC_NONE},
        '{A_NOP,        C_TRIM_STOP,    ADDR_LAST, UPC_EMIT},
        '{A_TRIM,       C_ALWAYS,       ADDR_LAST, UPC_F_TRIM},
        '{A_BADT,       C_ALWAYS,       ADDR_IDX,  UPC_EMIT},
        '{A_CURERR,     C_ALWAYS,       ADDR_IDX,  UPC_EMIT},
        // set state
        '{A_NOP,        C_BAD_SET,      ADDR_SLOT, UPC_BAD},
        '{A_SETST,      C_ALWAYS,       ADDR_SLOT, UPC_EMIT},
        // tick
        '{A_NOP,        C_LEN_ZERO,     ADDR_IDX,  UPC_EMIT},
        '{A_IDX_CUR1,   C_NEVER,        ADDR_IDX,  UPC_NONE},
        '{A_NOP,        C_IDX_LT_LEN,   ADDR_IDX,  UPC_T_TEST},
        '{A_IDX_SUB,    C_ALWAYS,       ADDR_IDX,  UPC_T_MOD},
        '{A_NOP,        C_CNT_ZERO,     ADDR_IDX,  UPC_EMIT},
        '{A_NOP,        C_IDX_CUR,      ADDR_IDX,  UPC_EMIT},
        '{A_NOP,        C_RUNNING,      ADDR_IDX,  UPC_T_SWITCH},
        '{A_NOP,        C_NOT_STOPPING, ADDR_IDX,  UPC_T_NEXT},
        '{A_CLEAR_IDX,  C_NEVER,        ADDR_IDX,  UPC_NONE},
        '{A_NOP,        C_TRIM_STOP,    ADDR_LAST, UPC_T_LENCHK},
        '{A_TRIM,       C_ALWAYS,       ADDR_LAST, UPC_T_TRIM},
        '{A_NOP,        C_LEN_ZERO,     ADDR_IDX,  UPC_EMIT},
        '{A_NEXT,       C_ALWAYS,       ADDR_IDX,  UPC_T_MOD},
        '{A_SWITCH,     C_ALWAYS,       ADDR_IDX,  UPC_EMIT},
        // result hand-off, shared by all programs
        '{A_EMIT,       C_NEVER,        ADDR_IDX,  UPC_NONE},
        '{A_NOP,        C_ALWAYS,       ADDR_IDX,  UPC_EMIT}
    };

    function automatic upc_t entry_of(input logic [1:0] op);
        upc_t e;
        unique case (op)
            OP_ALLOC: e = UPC_ALLOC;
            OP_FREE:  e = UPC_FREE;
            OP_SET:   e = UPC_SET;
            OP_TICK:  e = UPC_TICK;
            default:  e = UPC_EMIT;
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/prrs_if.sv
interface prrs_req_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            op;
    prrs_pkg::slot_t       slot;
    logic [1:0]            new_state;

    modport source (output valid, output op, output slot, output new_state, input ready);
    modport sink   (input valid, input op, input slot, input new_state, output ready);
endinterface

interface prrs_rsp_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    prrs_pkg::slot_t       slot_out;
    logic                  switched;

    modport source (output valid, output status, output slot_out, output switched, input ready);
    modport sink   (input valid, input status, input slot_out, input switched, output ready);
endinterface

FILE: rtl/prrs_datapath.sv
module prrs_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  prrs_pkg::dp_ctrl_t  ctrl,
    input  prrs_pkg::slot_t     slot,
    input  logic [1:0]          new_state,
    output prrs_pkg::dp_flags_t flags,
    output prrs_pkg::len_t      idx,
    output prrs_pkg::slot_t     cur
);
    import prrs_pkg::*;

    logic       used_reg  [MAX_SLOTS];
    logic [1:0] state_reg [MAX_SLOTS];
    len_t       len_reg;
    slot_t      cur_reg;
    len_t       idx_reg;
    len_t       cnt_reg;

    len_t       len_last;
    slot_t      rd_addr;
    slot_t      idx_slot;

    assign len_last = len_reg - LEN_W'(1);
    assign idx_slot = idx_reg[SLOT_W-1:0];

    // single read port, address picked by the control word
    always_comb
    begin
        unique case (ctrl.addr)
            ADDR_IDX:  rd_addr = idx_slot;
            ADDR_SLOT: rd_addr = slot;
            ADDR_LAST: rd_addr = len_last[SLOT_W-1:0];
            default:   rd_addr = idx_slot;
        endcase
    end

    always_comb
    begin
        flags.idx_ge_len  = idx_reg >= len_reg;
        flags.len_full    = len_reg == LEN_W'(MAX_SLOTS);
        flags.len_zero    = len_reg == '0;
        flags.slot_lt_len = LEN_W'(slot) < len_reg;
        flags.slot_is_cur = slot == cur_reg;
        flags.idx_is_cur  = idx_reg == LEN_W'(cur_reg);
        flags.cnt_zero    = cnt_reg == '0;
        flags.rd_used     = used_reg[rd_addr];
        flags.rd_state    = state_reg[rd_addr];
    end

    assign idx = idx_reg;
    assign cur = cur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                used_reg[i]  <= 1'b0;
                state_reg[i] <= RS_RUNNING;
            end
            len_reg <= '0;
            cur_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            unique case (ctrl.act)
                A_IDX_ZERO:
                begin
                    idx_reg <= '0;
                end
                A_NEXT:
                begin
                    idx_reg <= idx_reg + LEN_W'(1);
                    cnt_reg <= cnt_reg - LEN_W'(1);
                end
                A_IDX_CUR1:
                begin
                    idx_reg <= LEN_W'(cur_reg) + LEN_W'(1);
                    cnt_reg <= len_reg;
                end
                A_IDX_SUB:
                begin
                    idx_reg <= idx_reg - len_reg;
                end
                A_ALLOC:
                begin
                    used_reg[idx_slot]  <= 1'b1;
                    state_reg[idx_slot] <= RS_RUNNING;
                    // scan ran off the end: append a slot
                    if (idx_reg == len_reg)
                    begin
                        len_reg <= len_reg + LEN_W'(1);
                    end
                end
                A_CLEAR_SLOT:
                begin
                    used_reg[slot]  <= 1'b0;
                    state_reg[slot] <= RS_RUNNING;
                end
                A_CLEAR_IDX:
                begin
                    used_reg[idx_slot]  <= 1'b0;
                    state_reg[idx_slot] <= RS_RUNNING;
                end
                A_TRIM:
                begin
                    len_reg <= len_last;
                end
                A_SETST:
                begin
                    state_reg[slot] <= new_state;
                end
                A_SWITCH:
                begin
                    cur_reg <= idx_slot;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/process_table_round_robin_scheduler.sv
// Process slot table with a round-robin tick, run by a small microprogram:
// one control word per cycle from a 32-word constant table, with a program
// counter and conditional jumps. One request is worked on at a time; the
// next is taken the cycle after the program of the previous one has handed
// its result to the output register, and a result still waiting there holds
// the program on its last step. A free also drops the trailing unused slots,
// an allocate scans the slots in order for an unused one and appends one past
// the end when none is free, and a tick visits the slots in turn, wrapping its
// index, clearing stopping slots and trimming trailing unused ones as it goes;
// the serial scan through the slot table sets how long these three take.
module process_table_round_robin_scheduler (
    input  logic      clk,
    input  logic      rst_n,
    prrs_req_if.sink  req,
    prrs_rsp_if.source rsp
);
    import prrs_pkg::*;

    logic       busy_reg;
    upc_t       upc_reg;
    logic       out_valid_reg;

    logic [1:0] op_reg;
    slot_t      slot_reg;
    logic [1:0] ns_reg;
    logic [1:0] status_reg;
    slot_t      sout_reg;
    logic       sw_reg;

    logic [1:0] out_status_reg;
    slot_t      out_slot_reg;
    logic       out_switched_reg;

    uword_t     uw;
    logic       cond_true;
    logic       emit_go;
    logic       start;
    logic       bad_slot;
    dp_ctrl_t   dp_ctrl;
    dp_flags_t  flags;
    len_t       idx;
    slot_t      cur;

    prrs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dp_ctrl),
        .slot      (slot_reg),
        .new_state (ns_reg),
        .flags     (flags),
        .idx       (idx),
        .cur       (cur)
    );

    assign uw       = UCODE[upc_reg];
    assign start    = req.valid && !busy_reg;
    assign emit_go  = busy_reg && (uw.act == A_EMIT) && (!out_valid_reg || rsp.ready);
    assign bad_slot = !(flags.slot_lt_len && flags.rd_used);

    assign dp_ctrl.act  = busy_reg ? uw.act : A_NOP;
    assign dp_ctrl.addr = uw.addr;

    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:        cond_true = 1'b0;
            C_ALWAYS:       cond_true = 1'b1;
            C_IDX_GE_LEN:   cond_true = flags.idx_ge_len;
            C_IDX_LT_LEN:   cond_true = !flags.idx_ge_len;
            C_IDX_UNUSED:   cond_true = !flags.rd_used;
            C_BAD_SLOT:     cond_true = bad_slot;
            C_BAD_SET:      cond_true = bad_slot || (ns_reg > RS_STOPPING);
            C_SLOT_CUR:     cond_true = flags.slot_is_cur;
            C_LEN_FULL:     cond_true = flags.len_full;
            C_TRIM_STOP:    cond_true = flags.len_zero || flags.rd_used;
            C_LEN_ZERO:     cond_true = flags.len_zero;
            C_IDX_CUR:      cond_true = flags.idx_is_cur;
            C_RUNNING:      cond_true = flags.rd_used && (flags.rd_state == RS_RUNNING);
            C_NOT_STOPPING: cond_true = !(flags.rd_used && (flags.rd_state == RS_STOPPING));
            C_CNT_ZERO:     cond_true = flags.cnt_zero;
            default:        cond_true = 1'b0;
        endcase
    end

    assign req.ready    = !busy_reg;
    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.slot_out = out_slot_reg;
    assign rsp.switched = out_switched_reg;

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            upc_reg       <= UPC_EMIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                upc_reg  <= entry_of(req.op);
            end
            else if (busy_reg)
            begin
                if (uw.act == A_EMIT)
                begin
                    // hold here until the output register is free
                    if (emit_go)
                    begin
                        busy_reg <= 1'b0;
                    end
                end
                else if (cond_true)
                begin
                    upc_reg <= uw.target;
                end
                else
                begin
                    upc_reg <= upc_reg + UPC_W'(1);
                end
            end

            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg     <= req.op;
            slot_reg   <= req.slot;
            ns_reg     <= req.new_state;
            status_reg <= STAT_OK;
            sout_reg   <= '0;
            sw_reg     <= 1'b0;
        end
        else if (busy_reg)
        begin
            unique case (uw.act)
                A_ALLOC:  sout_reg   <= idx[SLOT_W-1:0];
                A_FULL:   status_reg <= STAT_FULL;
                A_BADT:   status_reg <= STAT_BAD;
                A_CURERR: status_reg <= STAT_CUR;
                A_SWITCH: sw_reg     <= 1'b1;
                default:
                begin
                end
            endcase
        end

        if (emit_go)
        begin
            out_status_reg   <= status_reg;
            out_slot_reg     <= (op_reg == OP_TICK) ? cur : sout_reg;
            out_switched_reg <= sw_reg;
        end
    end

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import prrs_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 200;
    localparam int ITEMS_PER_PHASE = 450;
    localparam int BLOCK_LEN = 45;
    localparam logic [1:0] RS_UNDEFINED = 2'd3;

    typedef struct {
        logic [1:0] status;
        slot_t      slot_out;
        logic       switched;
    } outcome_t;

    class sched_board;
        logic       used [MAX_SLOTS];
        logic [1:0] run_state [MAX_SLOTS];
        int         length;
        int         current;
        outcome_t   pending_outcomes [$];
        int         errors;
        int         op_count [4];
        int         full_count;
        int         switch_count;

        function new();
            foreach (used[i])
            begin
                used[i] = 1'b0;
                run_state[i] = RS_RUNNING;
            end
            length = 0;
            current = 0;
            errors = 0;
            full_count = 0;
            switch_count = 0;
            foreach (op_count[i])
                op_count[i] = 0;
        endfunction

        function bit target_ok(int s);
            return s < length && used[s];
        endfunction

        // clear a slot, then shrink the live length past trailing unused slots
        function void release_slot(int s);
            used[s] = 1'b0;
            run_state[s] = RS_RUNNING;
            while (length > 0 && !used[length-1])
                length--;
        endfunction

        function outcome_t next_outcome(logic [1:0] op, slot_t s, logic [1:0] ns);
            outcome_t o;
            int       pick;
            int       cur;
            int       steps;
            int       idx;
            o.status = STAT_OK;
            o.slot_out = '0;
            o.switched = 1'b0;
            case (op)
                OP_ALLOC:
                begin
                    pick = -1;
                    for (int i = 0; i < length; i++)
                    begin
                        if (pick < 0 && !used[i])
                            pick = i;
                    end
                    if (pick < 0 && length < MAX_SLOTS)
                    begin
                        pick = length;
                        length++;
                    end
                    if (pick >= 0)
                    begin
                        used[pick] = 1'b1;
                        run_state[pick] = RS_RUNNING;
                        o.slot_out = slot_t'(pick);
                    end
                    else
                        o.status = STAT_FULL;
                end
                OP_FREE:
                begin
                    if (!target_ok(s))
                        o.status = STAT_BAD;
                    else if (s == current)
                        o.status = STAT_CUR;
                    else
                        release_slot(s);
                end
                OP_SET:
                begin
                    if (!target_ok(s) || ns > RS_STOPPING)
                        o.status = STAT_BAD;
                    else
                        run_state[s] = ns;
                end
                default:
                begin
                    if (length > 0)
                    begin
                        cur = current;
                        steps = length;
                        idx = (cur + 1) % length;
                        for (int k = 0; k < steps; k++)
                        begin
                            if (idx == cur)
                                break;
                            if (used[idx] && run_state[idx] == RS_RUNNING)
                            begin
                                current = idx;
                                o.switched = 1'b1;
                                break;
                            end
                            if (used[idx] && run_state[idx] == RS_STOPPING)
                                release_slot(idx);
                            if (length == 0)
                                break;
                            // wrap against the length as it stands now
                            idx = (idx + 1) % length;
                        end
                    end
                    o.slot_out = slot_t'(current);
                end
            endcase
            return o;
        endfunction

        function void note_request(logic [1:0] op, slot_t s, logic [1:0] ns);
            op_count[op]++;
            pending_outcomes.push_back(next_outcome(op, s, ns));
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(logic [1:0] status, slot_t slot_out, logic switched);
            outcome_t o;
            if (pending_outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected: status %0d slot %0d sw %0d",
                         $time, status, slot_out, switched);
                return;
            end
            o = pending_outcomes.pop_front();
            if (o.status == STAT_FULL)
                full_count++;
            if (o.switched)
                switch_count++;
            compare_field("status", o.status, status);
            compare_field("slot_out", o.slot_out, slot_out);
            compare_field("switched", o.switched, switched);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   cycle_count = 0;

    sched_board board = new();

    prrs_req_if req_ch ();
    prrs_rsp_if rsp_ch ();

    process_table_round_robin_scheduler uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // response side: check on each accepted beat, then pick the next ready
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                board.check_result(rsp_ch.status, rsp_ch.slot_out, rsp_ch.switched);
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input logic [1:0] op, input slot_t s, input logic [1:0] ns);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.op <= op;
        req_ch.slot <= s;
        req_ch.new_state <= ns;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(op, s, ns);
    endtask

    task automatic send_random(input int alloc_w);
        int         live [$];
        int         r;
        logic [1:0] op;
        slot_t      s;
        logic [1:0] ns;
        foreach (board.used[i])
        begin
            if (board.used[i])
                live.push_back(i);
        end
        r = $urandom_range(99);
        if (r < alloc_w)
            op = OP_ALLOC;
        else
        begin
            case ($urandom_range(2))
                0:       op = OP_FREE;
                1:       op = OP_SET;
                default: op = OP_TICK;
            endcase
        end
        // mostly aim at live slots so frees and state writes take effect
        if (live.size() > 0 && $urandom_range(99) < 75)
            s = slot_t'(live[$urandom_range(live.size() - 1)]);
        else
            s = slot_t'($urandom_range(MAX_SLOTS - 1));
        if ($urandom_range(9) == 0)
            ns = RS_UNDEFINED;
        else
            ns = 2'($urandom_range(2));
        send_item(op, s, ns);
    endtask

    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int idle_by_phase [4];
        int stall_by_phase [4];
        int alloc_w;
        idle_by_phase = '{0, 64, 0, 8};
        stall_by_phase = '{0, 0, 64, 8};
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.op <= OP_TICK;
        req_ch.slot <= '0;
        req_ch.new_state <= RS_RUNNING;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, bad targets, current-slot free, stopping sweep
        send_item(OP_TICK, 4'd0, RS_RUNNING);
        send_item(OP_FREE, 4'd15, RS_RUNNING);
        send_item(OP_SET, 4'd0, RS_SLEEPING);
        repeat (4) send_item(OP_ALLOC, 4'd0, RS_RUNNING);
        send_item(OP_FREE, 4'd0, RS_RUNNING);
        send_item(OP_SET, 4'd1, RS_UNDEFINED);
        send_item(OP_SET, 4'd1, RS_SLEEPING);
        send_item(OP_SET, 4'd2, RS_STOPPING);
        send_item(OP_SET, 4'd3, RS_STOPPING);
        // sweeps out both stopping slots, trims, wraps back to current
        send_item(OP_TICK, 4'd0, RS_RUNNING);
        send_item(OP_SET, 4'd1, RS_RUNNING);
        send_item(OP_TICK, 4'd0, RS_RUNNING);
        send_item(OP_FREE, 4'd0, RS_RUNNING);
        send_item(OP_TICK, 4'd0, RS_RUNNING);
        send_item(OP_FREE, 4'd1, RS_RUNNING);
        send_item(OP_SET, 4'd15, RS_STOPPING);
        wait_all_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            for (int b = 0; b < ITEMS_PER_PHASE / BLOCK_LEN; b++)
            begin
                // pick at random how hard each block fills or drains the table
                case ($urandom_range(2))
                    0:       alloc_w = 10;
                    1:       alloc_w = 40;
                    default: alloc_w = 75;
                endcase
                repeat (BLOCK_LEN) send_random(alloc_w);
            end
            wait_all_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.pending_outcomes.size() != 0)
        begin
            board.errors++;
            $display("%0t: %0d results never arrived", $time, board.pending_outcomes.size());
        end
        $display("covered %0d allocate, %0d free, %0d set-state and %0d tick beats",
                 board.op_count[OP_ALLOC], board.op_count[OP_FREE],
                 board.op_count[OP_SET], board.op_count[OP_TICK]);
        $display("with %0d full-table refusals and %0d slot switches, %0d errors",
                 board.full_count, board.switch_count, board.errors);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
